[rtl/crc8_framed_uart_receiver_top_defines.svh]
// Assertion helpers for the frame deframer.
`ifndef CRC8_FRAMED_UART_RECEIVER_TOP_DEFINES_SVH
`define CRC8_FRAMED_UART_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define CFUR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfur assertion failed");

// condition must never be seen outside reset
`define CFUR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cfur forbidden condition seen");

`else

`define CFUR_ASSERT(lbl, clk, rst_n, prop)
`define CFUR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/cfur_pkg.sv]
package cfur_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int PAYLOAD_AW  = $clog2(MAX_PAYLOAD);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT    = 8'h00;
    localparam logic [BYTE_W-1:0] START_RESET = 8'hA5;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h5A;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } crc_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [BYTE_W-1:0] crc;
    } crc_stat_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] opcode;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              last;
    } result_t;

endpackage

[rtl/cfur_if.sv]
interface cfur_byte_if;
    import cfur_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfur_result_if;
    import cfur_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [BYTE_W-1:0] opcode;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic              last;

    modport source (output valid, output status, output opcode, output length,
                    output data, output data_valid, output last, input ready);
    modport sink   (input valid, input status, input opcode, input length,
                    input data, input data_valid, input last, output ready);
endinterface

[rtl/cfur_ram.sv]
module cfur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/cfur_crc8.sv]
module cfur_crc8 (
    input  logic                clk,
    input  logic                rst_n,
    input  cfur_pkg::crc_ctrl_t ctrl,
    output cfur_pkg::crc_stat_t stat
);
    import cfur_pkg::*;

    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [2:0]        count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              fb;

    // one message bit per cycle, MSB first
    assign fb = crc_reg[BYTE_W-1] ^ shift_reg[BYTE_W-1];

    always_comb
    begin
        crc_next   = crc_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        if (busy_reg)
        begin
            crc_next   = {crc_reg[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
            count_next = count_reg + 3'd1;
            if (count_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
        else if (ctrl.start)
        begin
            crc_next   = ctrl.clear ? CRC_INIT : crc_reg;
            shift_next = ctrl.data;
            count_next = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            shift_reg <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.crc  = crc_reg;

endmodule

[rtl/crc8_framed_uart_receiver_top.sv]
// Frame deframer for SOF, LEN, OP, payload, CRC, EOF byte streams with a
// CRC-8 (poly 0x07, init 0) over LEN, OP and payload. The CRC runs bit-serial,
// so LEN, OP and each payload byte hold off the next byte while the CRC folds
// it in; SOF, CRC and EOF bytes do not. After a good EOF the payload is read
// back from a 64-entry RAM with registered read, each result going through
// a read state and a load state that waits until the output register is free;
// a frame of zero length or a CRC error gives one result. Input stalls during
// that burst. A length above 64 drops back to hunting for SOF; a wrong EOF
// drops the frame. No clearing pass follows reset.
`include "crc8_framed_uart_receiver_top_defines.svh"

module crc8_framed_uart_receiver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cfur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfur_pkg::CFG_DATA_W-1:0] cfg_data,
    cfur_byte_if.sink                      rx,
    cfur_result_if.source                  res
);
    import cfur_pkg::*;

    typedef enum logic [3:0] {
        S_HUNT,
        S_LEN,
        S_OP,
        S_PAYLOAD,
        S_CRC,
        S_EOF,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_ONE
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] opcode_reg, opcode_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] rcv_crc_reg, rcv_crc_next;
    logic              pend_status_reg, pend_status_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;

    crc_ctrl_t         crc_ctrl;
    crc_stat_t         crc_stat;

    logic              in_phase;
    logic              rx_ready;
    logic              rx_fire;
    logic              out_free;
    logic              idx_room;
    logic [LEN_W-1:0]  idx_inc;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic              emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_RESET;
            end_byte_reg   <= END_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_data[BYTE_W-1:0];
                REG_END_BYTE:   end_byte_reg   <= cfg_data[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign in_phase = (state_reg == S_HUNT) || (state_reg == S_LEN) ||
                      (state_reg == S_OP) || (state_reg == S_PAYLOAD) ||
                      (state_reg == S_CRC) || (state_reg == S_EOF);
    assign rx_ready = in_phase && !crc_stat.busy;
    assign rx_fire  = rx.valid && rx_ready;
    assign rx.ready = rx_ready;
    assign out_free = !res_valid_reg || res.ready;

    assign idx_room  = idx_reg < LEN_W'(MAX_PAYLOAD);
    assign idx_inc   = idx_room ? (idx_reg + LEN_W'(1)) : idx_reg;
    assign ram_we    = rx_fire && (state_reg == S_PAYLOAD) && idx_room;
    assign emit_last = (idx_reg + LEN_W'(1)) == len_reg;

    cfur_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[PAYLOAD_AW-1:0]),
        .wdata (rx.rx_byte),
        .raddr (idx_reg[PAYLOAD_AW-1:0]),
        .rdata (ram_rdata)
    );

    cfur_crc8 u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .stat  (crc_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        opcode_next      = opcode_reg;
        idx_next         = idx_reg;
        rcv_crc_next     = rcv_crc_reg;
        pend_status_next = pend_status_reg;
        res_valid_next   = res_valid_reg && !res.ready;
        res_next         = res_reg;
        crc_ctrl.start   = 1'b0;
        crc_ctrl.clear   = 1'b0;
        crc_ctrl.data    = rx.rx_byte;

        unique case (state_reg)
            S_HUNT:
            begin
                if (rx_fire && (rx.rx_byte == start_byte_reg))
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (rx_fire)
                begin
                    if (rx.rx_byte > BYTE_W'(MAX_PAYLOAD))
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        len_next       = rx.rx_byte[LEN_W-1:0];
                        idx_next       = '0;
                        crc_ctrl.start = 1'b1;
                        crc_ctrl.clear = 1'b1;
                        state_next     = S_OP;
                    end
                end
            end
            S_OP:
            begin
                if (rx_fire)
                begin
                    opcode_next    = rx.rx_byte;
                    crc_ctrl.start = 1'b1;
                    state_next     = (len_reg == '0) ? S_CRC : S_PAYLOAD;
                end
            end
            S_PAYLOAD:
            begin
                if (rx_fire)
                begin
                    idx_next       = idx_inc;
                    crc_ctrl.start = 1'b1;
                    if (idx_inc >= len_reg)
                    begin
                        state_next = S_CRC;
                    end
                end
            end
            S_CRC:
            begin
                if (rx_fire)
                begin
                    rcv_crc_next = rx.rx_byte;
                    state_next   = S_EOF;
                end
            end
            S_EOF:
            begin
                if (rx_fire)
                begin
                    state_next = S_HUNT;
                    if (rx.rx_byte == end_byte_reg)
                    begin
                        if (crc_stat.crc != rcv_crc_reg)
                        begin
                            pend_status_next = STATUS_CRC_ERR;
                            state_next       = S_EMIT_ONE;
                        end
                        else if (len_reg == '0)
                        begin
                            pend_status_next = STATUS_OK;
                            state_next       = S_EMIT_ONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_EMIT_RD;
                        end
                    end
                end
            end
            S_EMIT_RD:
            begin
                // RAM read in flight
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.status     = STATUS_OK;
                    res_next.opcode     = opcode_reg;
                    res_next.length     = len_reg;
                    res_next.data       = ram_rdata;
                    res_next.data_valid = 1'b1;
                    res_next.last       = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_ONE:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.status     = pend_status_reg;
                    res_next.opcode     = opcode_reg;
                    res_next.length     = len_reg;
                    res_next.data       = '0;
                    res_next.data_valid = 1'b0;
                    res_next.last       = 1'b1;
                    state_next          = S_HUNT;
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_HUNT;
            len_reg         <= '0;
            opcode_reg      <= '0;
            idx_reg         <= '0;
            rcv_crc_reg     <= '0;
            pend_status_reg <= STATUS_OK;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            opcode_reg      <= opcode_next;
            idx_reg         <= idx_next;
            rcv_crc_reg     <= rcv_crc_next;
            pend_status_reg <= pend_status_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.status     = res_reg.status;
    assign res.opcode     = res_reg.opcode;
    assign res.length     = res_reg.length;
    assign res.data       = res_reg.data;
    assign res.data_valid = res_reg.data_valid;
    assign res.last       = res_reg.last;

    // no byte may be taken while the serial CRC is still folding the last one
    `CFUR_ASSERT_NEVER(a_no_accept_crc_busy, clk, rst_n, rx.ready && crc_stat.busy)
    // an oversized length always aborts to hunting
    `CFUR_ASSERT(a_len_abort, clk, rst_n, (rx_fire && (state_reg == S_LEN) && (rx.rx_byte > BYTE_W'(MAX_PAYLOAD))) |=> (state_reg == S_HUNT))
    // readback index stays inside the frame
    `CFUR_ASSERT(a_emit_idx, clk, rst_n, ((state_reg == S_EMIT_RD) || (state_reg == S_EMIT_LD)) |-> (idx_reg < len_reg))
    // results without a payload byte carry zero data and close the run
    `CFUR_ASSERT(a_nodata_result, clk, rst_n, (res.valid && !res.data_valid) |-> ((res.data == '0) && res.last))

endmodule

[tb/cfur_frame_checker.sv]
`timescale 1ns / 1ps

module cfur_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfur_pkg::CFG_DATA_W-1:0] cfg_data,
    cfur_byte_if                            rx,
    cfur_result_if                          res,
    output int                              errors,
    output int                              pending
);
    import cfur_pkg::*;

    typedef enum logic [2:0] {
        SEEK_SOF,
        TAKE_LEN,
        TAKE_OP,
        TAKE_PAYLOAD,
        TAKE_CRC,
        TAKE_EOF
    } deframe_phase_e;

    deframe_phase_e    phase;
    logic [BYTE_W-1:0] sof_byte;
    logic [BYTE_W-1:0] eof_byte;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] frame_op;
    logic [LEN_W-1:0]  fill_idx;
    logic [BYTE_W-1:0] crc_acc;
    logic [BYTE_W-1:0] crc_rx;
    logic [BYTE_W-1:0] payload [MAX_PAYLOAD];
    result_t           expected_beats [$];

    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic queue_beat(input logic st, input logic [BYTE_W-1:0] d,
                              input logic dv, input logic lst);
        result_t r;
        r.status     = st;
        r.opcode     = frame_op;
        r.length     = frame_len;
        r.data       = d;
        r.data_valid = dv;
        r.last       = lst;
        expected_beats.push_back(r);
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            SEEK_SOF:
            begin
                if (b == sof_byte)
                    phase = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                // oversize length aborts back to hunting
                if (b > MAX_PAYLOAD)
                    phase = SEEK_SOF;
                else
                begin
                    frame_len = b[LEN_W-1:0];
                    fill_idx  = '0;
                    crc_acc   = crc8_next(CRC_INIT, b);
                    phase     = TAKE_OP;
                end
            end
            TAKE_OP:
            begin
                frame_op = b;
                crc_acc  = crc8_next(crc_acc, b);
                phase    = (frame_len == 0) ? TAKE_CRC : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD:
            begin
                if (fill_idx < MAX_PAYLOAD)
                begin
                    payload[fill_idx[PAYLOAD_AW-1:0]] = b;
                    fill_idx = fill_idx + 1'b1;
                end
                crc_acc = crc8_next(crc_acc, b);
                if (fill_idx >= frame_len)
                    phase = TAKE_CRC;
            end
            TAKE_CRC:
            begin
                crc_rx = b;
                phase  = TAKE_EOF;
            end
            TAKE_EOF:
            begin
                if (b == eof_byte)
                begin
                    if (crc_acc != crc_rx)
                        queue_beat(STATUS_CRC_ERR, '0, 1'b0, 1'b1);
                    else if (frame_len == 0)
                        queue_beat(STATUS_OK, '0, 1'b0, 1'b1);
                    else
                    begin
                        for (int i = 0; i < frame_len; i++)
                        begin
                            queue_beat(STATUS_OK, payload[i], 1'b1, (i + 1 == frame_len));
                        end
                    end
                end
                phase = SEEK_SOF;
            end
            default: phase = SEEK_SOF;
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            phase     = SEEK_SOF;
            sof_byte  = START_RESET;
            eof_byte  = END_RESET;
            frame_len = '0;
            frame_op  = '0;
            fill_idx  = '0;
            crc_acc   = '0;
            crc_rx    = '0;
            errors    = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_BYTE: sof_byte = cfg_data;
                    REG_END_BYTE:   eof_byte = cfg_data;
                    default: ;
                endcase
            end
            if (rx.valid && rx.ready)
                predict_byte(rx.rx_byte);
            if (res.valid && res.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: opcode 0x%0h length %0d data 0x%0h",
                           res.opcode, res.length, res.data);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("status", want.status, res.status);
                    compare_field("opcode", want.opcode, res.opcode);
                    compare_field("length", want.length, res.length);
                    compare_field("data", want.data, res.data);
                    compare_field("data_valid", want.data_valid, res.data_valid);
                    compare_field("last", want.last, res.last);
                end
            end
        end
        pending = expected_beats.size();
    end

endmodule

[tb/crc8_framed_uart_receiver_top_tb.sv]
`timescale 1ns / 1ps

module crc8_framed_uart_receiver_top_tb;
    import cfur_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 600;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_EOF,
        FR_OVERSIZE
    } frame_kind_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    cfur_byte_if   rx_if ();
    cfur_result_if res_if ();

    int          errors;
    int          pending;
    int          bytes_sent    = 0;
    bit          src_gaps      = 1'b1;
    bit          snk_gaps      = 1'b1;
    bit          stall_pending = 1'b0;
    logic [7:0]  cur_sof       = START_RESET;
    logic [7:0]  cur_eof       = END_RESET;

    always #1 clk = ~clk;

    crc8_framed_uart_receiver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .res       (res_if)
    );

    cfur_frame_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .res       (res_if),
        .errors    (errors),
        .pending   (pending)
    );

    // sink side: random backpressure, plus one long hold-off on request
    initial
    begin : sink_side
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pending)
            begin
                stall_pending = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (snk_gaps)
                res_if.ready <= ($urandom_range(99) >= 25);
            else
                res_if.ready <= 1'b1;
        end
    end

    // frame builder needs its own CRC to form good and bad checksums
    function automatic logic [7:0] frame_crc_step(input logic [7:0] c0, input logic [7:0] b);
        logic [7:0] c;
        c = c0 ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (src_gaps && $urandom_range(99) < 25)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int len,
                              input logic [7:0] op, input int fill = -1);
        logic [7:0] crc;
        logic [7:0] d;
        send_byte(cur_sof);
        if (kind == FR_OVERSIZE)
            send_byte(8'(len));
        else
        begin
            send_byte(8'(len));
            crc = frame_crc_step(CRC_INIT, 8'(len));
            send_byte(op);
            crc = frame_crc_step(crc, op);
            for (int i = 0; i < len; i++)
            begin
                d = (fill < 0) ? 8'($urandom) : 8'(fill);
                send_byte(d);
                crc = frame_crc_step(crc, d);
            end
            if (kind == FR_BAD_CRC)
                crc = crc ^ 8'($urandom_range(255, 1));
            send_byte(crc);
            if (kind == FR_BAD_EOF)
                send_byte(cur_eof ^ 8'($urandom_range(255, 1)));
            else
                send_byte(cur_eof);
        end
    endtask

    // bytes ignored while hunting
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            while (b == cur_sof)
                b = 8'($urandom);
            send_byte(b);
        end
    endtask

    task automatic random_frame();
        int pick;
        int len;
        pick = $urandom_range(99);
        len  = ($urandom_range(19) == 0) ? MAX_PAYLOAD : $urandom_range(6);
        if (pick < 70)
            send_frame(FR_GOOD, len, 8'($urandom));
        else if (pick < 80)
            send_frame(FR_BAD_CRC, len, 8'($urandom));
        else if (pick < 88)
            send_frame(FR_BAD_EOF, len, 8'($urandom));
        else if (pick < 94)
            send_frame(FR_OVERSIZE, $urandom_range(255, MAX_PAYLOAD + 1), 8'h00);
        else
            send_noise($urandom_range(3, 1));
    endtask

    // register writes only once every result is out and the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        rx_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_framing(input logic [7:0] sof, input logic [7:0] eof);
        write_reg(REG_START_BYTE, sof);
        write_reg(REG_END_BYTE, eof);
        cur_sof = sof;
        cur_eof = eof;
    endtask

    initial
    begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: hunt noise, zero length, byte extremes, bad CRC, bad EOF, oversize
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FR_GOOD, 0, 8'h00);
        send_frame(FR_GOOD, 1, 8'hFF, 8'hFF);
        send_frame(FR_BAD_CRC, 1, 8'h3C, 8'h00);
        send_frame(FR_BAD_EOF, 0, 8'h11);
        send_frame(FR_OVERSIZE, MAX_PAYLOAD + 1, 8'h00);
        send_frame(FR_OVERSIZE, 255, 8'h00);

        // reset framing, random gaps, one full-size frame
        send_frame(FR_GOOD, MAX_PAYLOAD, 8'($urandom));
        while (bytes_sent < 140)
            random_frame();

        // no idling on either side
        set_framing(8'h00, 8'hFF);
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        while (bytes_sent < 240)
            random_frame();

        // long sink hold-off while frames keep coming; input must back up
        set_framing(8'hFF, 8'h00);
        src_gaps      = 1'b1;
        snk_gaps      = 1'b1;
        stall_pending = 1'b1;
        repeat (4) send_frame(FR_GOOD, 16, 8'($urandom));
        while (bytes_sent < 380)
            random_frame();

        set_framing(8'($urandom), 8'($urandom));
        while (bytes_sent < 420)
            random_frame();

        // start and end share a value
        set_framing(8'h7E, 8'h7E);
        while (bytes_sent < 460)
            random_frame();

        @(negedge clk);
        rx_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("crc8_framed_uart_receiver_top regression: pass");
        else
            $display("crc8_framed_uart_receiver_top regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("crc8_framed_uart_receiver_top regression: fail");
        $finish;
    end

endmodule
